/* rtl/fab_pkg.sv */
package fab_pkg;

	localparam int POS_W = 8;
	localparam int SIZE_W = 9;
	localparam int WORD_W = 32;

	// Positions reachable through the 8-bit coordinate fields.
	localparam int POS_LIMIT = 256;

	// Depth of the queue between front and back.
	localparam int Q_DEPTH = 2;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [WORD_W-1:0] word_t;

	localparam logic [1:0] FUNC_PLOT = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_READ_FORMAT = 2'd2;

	localparam logic [1:0] FMT_RGBA = 2'd0;
	localparam logic [1:0] FMT_BGRA = 2'd1;
	localparam logic [1:0] FMT_BGRX = 2'd2;
	localparam logic [1:0] FMT_OPAQUE = 2'd3;

	// Work kinds handed from front to back.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_BLEND = 2'd1;
	localparam logic [1:0] OP_FILL = 2'd2;
	localparam logic [1:0] OP_READ = 2'd3;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam size_t FRAME_SIZE_RESET = 9'd256;

	typedef struct packed {
		logic [1:0] func;
		pos_t pos_x;
		pos_t pos_y;
		word_t color;
	} item_t;

	typedef struct packed {
		word_t pixel_word;
		logic out_of_range;
	} result_t;

	typedef struct packed {
		logic [1:0] index;
		size_t value;
	} cfg_t;

	// For OP_FILL the position fields carry the last column and last row.
	typedef struct packed {
		logic [1:0] kind;
		pos_t pos_x;
		pos_t pos_y;
		word_t color;
		logic oor;
	} op_t;

	// v / 255 for v up to 255*255: reciprocal multiply with correction.
	function automatic logic [7:0] div255(input logic [15:0] v);
		logic [15:0] t;
		t = v + 16'd1 + (v >> 8);
		return t[15:8];
	endfunction

	function automatic word_t format_word(input word_t p, input logic [1:0] fmt);
		word_t w;
		unique case (fmt)
			FMT_BGRA: w = {p[15:8], p[23:16], p[31:24], p[7:0]};
			FMT_BGRX: w = {p[15:8], p[23:16], p[31:24], 8'h00};
			FMT_OPAQUE: w = {p[31:8], ALPHA_OPAQUE};
			default: w = p;
		endcase
		return w;
	endfunction

endpackage

/* rtl/fab_stream_if.sv */
interface fab_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/framebuffer_alpha_blend_store.sv */
// Pixel store of MAX_WIDTH x MAX_HEIGHT RGBA8888 words with source-over blending.
// The item channel takes one word per cycle into a two-entry queue while the
// queue has room; the back end then works one entry at a time on a single
// memory with one write and one registered read port. An opaque plot is one
// write; a blended plot is read, multiply, divide and write; a read is a memory
// read and a result load; an out-of-range read loads its result alone; a clear
// writes each active pixel (width x height). Plots outside the frame,
// transparent plots and unused codes are dropped at the front and cost the
// back nothing. After reset the memory is swept to zero, all MAX_WIDTH x
// MAX_HEIGHT words (65536 by default); item ready stays low until that sweep
// ends, while configuration writes are taken at any time. A read result sits
// in an output register, so the front keeps accepting words while a result
// waits to be taken. Write configuration only while the block is idle.
module framebuffer_alpha_blend_store #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input logic clk,
	input logic arst_n,
	fab_stream_if.sink item,
	fab_stream_if.source result,
	fab_stream_if.sink cfg
);

	// front to queue
	logic q_push;
	fab_pkg::op_t q_entry;
	logic q_full;

	// queue to back
	logic head_valid;
	fab_pkg::op_t head;
	logic pop;

	// shared status
	logic init_busy;
	logic [1:0] read_format;

	// Accept and classify words, hold the configuration registers.
	fab_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cfg(cfg),
		.init_busy(init_busy),
		.q_full(q_full),
		.q_push(q_push),
		.q_entry(q_entry),
		.read_format(read_format)
	);

	// Decouple front and back so each stalls on its own.
	fab_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_entry(q_entry),
		.full(q_full),
		.head_valid(head_valid),
		.head(head),
		.pop(pop)
	);

	// Own the memory: sweep, write, blend, fill and read.
	fab_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.read_format(read_format),
		.init_busy(init_busy),
		.result(result)
	);

endmodule

/* rtl/fab_front.sv */
module fab_front #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input logic clk,
	input logic arst_n,
	fab_stream_if.sink item,
	fab_stream_if.sink cfg,
	input logic init_busy,
	input logic q_full,
	output logic q_push,
	output fab_pkg::op_t q_entry,
	output logic [1:0] read_format
);

	fab_pkg::size_t frame_width_q;
	fab_pkg::size_t frame_height_q;
	logic [1:0] read_format_q;
	fab_pkg::size_t lim_w;
	fab_pkg::size_t lim_h;
	logic in_frame;
	logic empty;
	logic keep;

	assign cfg.ready = 1'b1;
	assign read_format = read_format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= fab_pkg::FRAME_SIZE_RESET;
			frame_height_q <= fab_pkg::FRAME_SIZE_RESET;
			read_format_q <= fab_pkg::FMT_RGBA;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				fab_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg.data.value;
				fab_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg.data.value;
				fab_pkg::REG_READ_FORMAT: read_format_q <= cfg.data.value[1:0];
				default: ;
			endcase
		end
	end

	// Clamp the active frame to the store and to the reachable positions.
	always_comb begin
		lim_w = frame_width_q;
		if (MAX_WIDTH < int'(lim_w)) lim_w = fab_pkg::size_t'(MAX_WIDTH);
		if (fab_pkg::POS_LIMIT < int'(lim_w)) lim_w = fab_pkg::size_t'(fab_pkg::POS_LIMIT);
		lim_h = frame_height_q;
		if (MAX_HEIGHT < int'(lim_h)) lim_h = fab_pkg::size_t'(MAX_HEIGHT);
		if (fab_pkg::POS_LIMIT < int'(lim_h)) lim_h = fab_pkg::size_t'(fab_pkg::POS_LIMIT);
	end

	assign in_frame = ({1'b0, item.data.pos_x} < lim_w) && ({1'b0, item.data.pos_y} < lim_h);
	assign empty = (lim_w == '0) || (lim_h == '0);

	assign item.ready = !init_busy && !q_full;

	// Classify the word; drop what changes nothing.
	always_comb begin
		keep = 1'b0;
		q_entry.kind = fab_pkg::OP_READ;
		q_entry.pos_x = item.data.pos_x;
		q_entry.pos_y = item.data.pos_y;
		q_entry.color = item.data.color;
		q_entry.oor = !in_frame;
		unique case (item.data.func)
			fab_pkg::FUNC_PLOT: begin
				keep = in_frame && (item.data.color[7:0] != 8'h00);
				q_entry.kind = (item.data.color[7:0] == fab_pkg::ALPHA_OPAQUE) ?
					fab_pkg::OP_WRITE : fab_pkg::OP_BLEND;
			end
			fab_pkg::FUNC_CLEAR: begin
				keep = !empty;
				q_entry.kind = fab_pkg::OP_FILL;
				q_entry.pos_x = fab_pkg::pos_t'(lim_w - 9'd1);
				q_entry.pos_y = fab_pkg::pos_t'(lim_h - 9'd1);
			end
			fab_pkg::FUNC_READ: begin
				keep = 1'b1;
				q_entry.kind = fab_pkg::OP_READ;
			end
			default: keep = 1'b0;
		endcase
	end

	assign q_push = item.valid && item.ready && keep;

endmodule

/* rtl/fab_queue.sv */
module fab_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input fab_pkg::op_t push_entry,
	output logic full,
	output logic head_valid,
	output fab_pkg::op_t head,
	input logic pop
);

	localparam int PTR_W = (fab_pkg::Q_DEPTH > 1) ? $clog2(fab_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(fab_pkg::Q_DEPTH + 1);

	fab_pkg::op_t slot_q [fab_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(fab_pkg::Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(fab_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= advance(wr_ptr_q);
			if (do_pop) rd_ptr_q <= advance(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/fab_back.sv */
module fab_back #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256
) (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input fab_pkg::op_t head,
	output logic pop,
	input logic [1:0] read_format,
	output logic init_busy,
	fab_stream_if.source result
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_BLEND_MUL = 3'd2;
	localparam logic [2:0] ST_BLEND_WR = 3'd3;
	localparam logic [2:0] ST_FILL = 3'd4;
	localparam logic [2:0] ST_READ_RD = 3'd5;

	fab_pkg::word_t pixel_mem_q [DEPTH];
	fab_pkg::word_t rdata_q;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [AW-1:0] init_addr_q;
	fab_pkg::pos_t col_q;
	fab_pkg::pos_t row_q;
	fab_pkg::pos_t last_col_q;
	fab_pkg::pos_t last_row_q;
	logic [AW-1:0] addr_q;
	fab_pkg::word_t color_q;
	logic [15:0] sum_q [3];
	logic res_valid_q;
	fab_pkg::result_t res_q;

	logic we;
	logic re;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	fab_pkg::word_t wdata;
	logic [AW-1:0] head_addr;
	logic [AW-1:0] fill_addr;
	logic fill_last;
	logic init_last;
	logic out_free;
	logic res_load;
	fab_pkg::result_t res_d;
	fab_pkg::word_t blend_word;

	function automatic logic [AW-1:0] addr_of(input fab_pkg::pos_t x, input fab_pkg::pos_t y);
		return AW'(32'(y) * 32'(MAX_WIDTH) + 32'(x));
	endfunction

	assign head_addr = addr_of(head.pos_x, head.pos_y);
	assign fill_addr = addr_of(col_q, row_q);
	assign fill_last = (col_q == last_col_q) && (row_q == last_row_q);
	assign init_last = (init_addr_q == AW'(DEPTH - 1));
	assign init_busy = (state_q == ST_INIT);
	assign out_free = !res_valid_q || result.ready;
	assign blend_word = {fab_pkg::div255(sum_q[0]), fab_pkg::div255(sum_q[1]),
		fab_pkg::div255(sum_q[2]), fab_pkg::ALPHA_OPAQUE};

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		waddr = head_addr;
		raddr = head_addr;
		wdata = head.color;
		pop = 1'b0;
		res_load = 1'b0;
		res_d = '0;
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				we = 1'b1;
				waddr = init_addr_q;
				wdata = '0;
				if (init_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (head_valid) begin
					unique case (head.kind)
						fab_pkg::OP_WRITE: begin
							we = 1'b1;
							pop = 1'b1;
						end
						fab_pkg::OP_BLEND: begin
							re = 1'b1;
							pop = 1'b1;
							state_d = ST_BLEND_MUL;
						end
						fab_pkg::OP_FILL: begin
							pop = 1'b1;
							state_d = ST_FILL;
						end
						default: begin
							if (out_free) begin
								pop = 1'b1;
								if (head.oor) begin
									res_load = 1'b1;
									res_d.out_of_range = 1'b1;
								end else begin
									re = 1'b1;
									state_d = ST_READ_RD;
								end
							end
						end
					endcase
				end
			end
			ST_BLEND_MUL: state_d = ST_BLEND_WR;
			ST_BLEND_WR: begin
				we = 1'b1;
				waddr = addr_q;
				wdata = blend_word;
				state_d = ST_IDLE;
			end
			ST_FILL: begin
				we = 1'b1;
				waddr = fill_addr;
				wdata = color_q;
				if (fill_last) state_d = ST_IDLE;
			end
			ST_READ_RD: begin
				res_load = 1'b1;
				res_d.pixel_word = fab_pkg::format_word(rdata_q, read_format);
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) pixel_mem_q[waddr] <= wdata;
		if (re) rdata_q <= pixel_mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop) begin
			addr_q <= head_addr;
			color_q <= head.color;
			last_col_q <= head.pos_x;
			last_row_q <= head.pos_y;
		end
		if (state_q == ST_BLEND_MUL) begin
			for (int k = 0; k < 3; k++) begin
				sum_q[k] <= 16'(color_q[31-8*k -: 8]) * 16'(color_q[7:0]) +
					16'(rdata_q[31-8*k -: 8]) * 16'(fab_pkg::ALPHA_OPAQUE - color_q[7:0]);
			end
		end
		if (res_load) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			init_addr_q <= '0;
			col_q <= '0;
			row_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) init_addr_q <= init_addr_q + 1'b1;
			if (state_q == ST_IDLE && pop) begin
				col_q <= '0;
				row_q <= '0;
			end else if (state_q == ST_FILL) begin
				if (col_q == last_col_q) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (res_load) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data = res_q;

endmodule

/* rtl/fab_checker.sv */
module fab_checker (
	input logic clk,
	input logic arst_n,
	input logic item_ready,
	input logic res_valid,
	input logic res_ready,
	input logic [31:0] res_word,
	input logic res_oor
);

	// The memory sweep holds item ready low right after reset.
	a_sweep_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !item_ready)
		else $error("item ready during clearing sweep");

	// An out-of-range read carries an all-zero word.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_oor |-> res_word == 32'h0)
		else $error("out-of-range read with nonzero word");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_word) && $stable(res_oor))
		else $error("result changed while stalled");

endmodule

bind framebuffer_alpha_blend_store fab_checker u_fab_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_ready(item.ready),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_word(result.data.pixel_word),
	.res_oor(result.data.out_of_range)
);

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

	// Store geometry the block is built with here.
	localparam int FB_W = 256;
	localparam int FB_H = 256;

	// Codes the package leaves unnamed: an unused operation and an unused register.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// Longest stretch with no handshake on any channel. The worst case is the reset
	// sweep or a full-frame clear, each covering all 65536 pixels, with ample margin.
	localparam int STALL_LIMIT = 250000;

	// Clears in the random part only where the frame is small enough to be cheap.
	localparam int CHEAP_CLEAR = 4096;
	localparam int PHASES = 12;
	localparam int WORDS_PER_PHASE = 65;

	logic clk = 1'b0;
	logic arst_n;

	fab_stream_if #(.T(fab_pkg::item_t)) item_ch ();
	fab_stream_if #(.T(fab_pkg::result_t)) result_ch ();
	fab_stream_if #(.T(fab_pkg::cfg_t)) cfg_ch ();

	framebuffer_alpha_blend_store #(
		.MAX_WIDTH(FB_W),
		.MAX_HEIGHT(FB_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	always #1 clk = ~clk;

	// Words waiting to go out, filled by the stimulus process.
	fab_pkg::item_t pending_items[$];
	fab_pkg::cfg_t reg_writes[$];

	// Read results the shadow frame buffer says must come back, oldest first.
	fab_pkg::result_t expected_reads[$];

	// Shadow copy of the pixel store and of the registers.
	bit [31:0] shadow_fb [0:FB_W*FB_H-1];
	logic [8:0] cfg_width = 9'd256;
	logic [8:0] cfg_height = 9'd256;
	logic [1:0] cfg_fmt = fab_pkg::FMT_RGBA;

	// Recently plotted positions, so reads and blends hit pixels that hold data.
	fab_pkg::pos_t hot_x [4];
	fab_pkg::pos_t hot_y [4];
	int hot_fill = 0;
	int hot_next = 0;

	bit calm = 1'b0;
	int send_gap;
	int take_gap;
	int quiet_cycles = 0;
	int fault_count = 0;
	int n_plot = 0;
	int n_clear = 0;
	int n_read = 0;
	int n_oor = 0;
	int n_regw = 0;

	function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] d,
			input logic [7:0] a);
		int unsigned sv, dv, av;
		sv = s;
		dv = d;
		av = a;
		return 8'((sv * av + dv * (255 - av)) / 255);
	endfunction

	// Arrange the stored RGBA bytes in the selected output format, forcing or zeroing alpha where it asks.
	function automatic fab_pkg::word_t order_bytes(input fab_pkg::word_t p,
			input logic [1:0] fmt);
		case (fmt)
			fab_pkg::FMT_BGRA: return {p[15:8], p[23:16], p[31:24], p[7:0]};
			fab_pkg::FMT_BGRX: return {p[15:8], p[23:16], p[31:24], 8'h00};
			fab_pkg::FMT_OPAQUE: return {p[31:8], 8'hFF};
			default: return p;
		endcase
	endfunction

	// Advance the shadow store by one accepted word; queue the result of a read.
	task automatic apply_pixel_op(input fab_pkg::item_t it);
		int unsigned wa, ha, addr, yy, xx;
		bit in_frame;
		fab_pkg::word_t d;
		fab_pkg::result_t r;
		wa = (cfg_width > FB_W) ? FB_W : cfg_width;
		ha = (cfg_height > FB_H) ? FB_H : cfg_height;
		in_frame = (it.pos_x < wa) && (it.pos_y < ha);
		addr = it.pos_y * FB_W + it.pos_x;
		case (it.func)
			fab_pkg::FUNC_PLOT: begin
				n_plot++;
				if (in_frame && it.color[7:0] == 8'hFF)
					shadow_fb[addr] = it.color;
				else if (in_frame && it.color[7:0] != 8'h00) begin
					d = shadow_fb[addr];
					shadow_fb[addr] = {mix_channel(it.color[31:24], d[31:24], it.color[7:0]),
						mix_channel(it.color[23:16], d[23:16], it.color[7:0]),
						mix_channel(it.color[15:8], d[15:8], it.color[7:0]), 8'hFF};
				end
			end
			fab_pkg::FUNC_CLEAR: begin
				n_clear++;
				for (yy = 0; yy < ha; yy++)
					for (xx = 0; xx < wa; xx++)
						shadow_fb[yy * FB_W + xx] = it.color;
			end
			fab_pkg::FUNC_READ: begin
				n_read++;
				if (in_frame) begin
					r.pixel_word = order_bytes(shadow_fb[addr], cfg_fmt);
					r.out_of_range = 1'b0;
				end else begin
					r.pixel_word = '0;
					r.out_of_range = 1'b1;
					n_oor++;
				end
				expected_reads.push_back(r);
			end
			default: ;
		endcase
	endtask

	function automatic fab_pkg::item_t pixel_op(input logic [1:0] f, input fab_pkg::pos_t x,
			input fab_pkg::pos_t y, input fab_pkg::word_t c);
		fab_pkg::item_t it;
		it.func = f;
		it.pos_x = x;
		it.pos_y = y;
		it.color = c;
		return it;
	endfunction

	// One random word for a frame of w x h active pixels. Most positions land inside
	// the frame or on a recently plotted pixel; the rest are anywhere.
	function automatic fab_pkg::item_t random_pixel_op(input int unsigned w,
			input int unsigned h, input bit clears_ok);
		fab_pkg::item_t it;
		int unsigned roll, k, j;
		logic [7:0] alpha;
		roll = $urandom_range(0, 99);
		k = $urandom_range(0, 9);
		if (k < 4 && hot_fill != 0) begin
			j = $urandom_range(0, hot_fill - 1);
			it.pos_x = hot_x[j];
			it.pos_y = hot_y[j];
		end else if (k < 8 && w != 0 && h != 0) begin
			it.pos_x = fab_pkg::pos_t'($urandom_range(0, w - 1));
			it.pos_y = fab_pkg::pos_t'($urandom_range(0, h - 1));
		end else begin
			it.pos_x = fab_pkg::pos_t'($urandom);
			it.pos_y = fab_pkg::pos_t'($urandom);
		end
		it.color = $urandom;
		if (roll < 3)
			it.func = FUNC_UNUSED;
		else if (roll < 5 && clears_ok)
			it.func = fab_pkg::FUNC_CLEAR;
		else if (roll < 55) begin
			it.func = fab_pkg::FUNC_PLOT;
			// Lean on the alpha corners: transparent, opaque, and one step off each.
			case ($urandom_range(0, 7))
				0: alpha = 8'h00;
				1: alpha = 8'hFF;
				2: alpha = 8'h01;
				3: alpha = 8'hFE;
				default: alpha = 8'($urandom);
			endcase
			it.color[7:0] = alpha;
			hot_x[hot_next] = it.pos_x;
			hot_y[hot_next] = it.pos_y;
			hot_next = (hot_next + 1) % 4;
			if (hot_fill < 4)
				hot_fill++;
		end else
			it.func = fab_pkg::FUNC_READ;
		return it;
	endfunction

	// Wait until every word is taken and every read has come back, then let the
	// back end settle so no plot is still in flight.
	task automatic drain_block();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_ch.valid || expected_reads.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [8:0] w, input logic [8:0] h,
			input logic [8:0] fmt_val);
		reg_writes.push_back(fab_pkg::cfg_t'{index: fab_pkg::REG_FRAME_WIDTH, value: w});
		reg_writes.push_back(fab_pkg::cfg_t'{index: fab_pkg::REG_FRAME_HEIGHT, value: h});
		reg_writes.push_back(fab_pkg::cfg_t'{index: fab_pkg::REG_READ_FORMAT,
			value: fmt_val});
		do
			@(negedge clk);
		while (reg_writes.size() != 0 || cfg_ch.valid);
	endtask

	// Item driver: hold a word until taken, pop the next one, and idle in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.data <= '0;
			send_gap <= 0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (send_gap != 0) begin
				item_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				// Start a random idle gap.
				item_ch.valid <= 1'b0;
				send_gap <= $urandom_range(0, 11);
			end else if (pending_items.size() != 0) begin
				item_ch.valid <= 1'b1;
				item_ch.data <= pending_items.pop_front();
			end else
				item_ch.valid <= 1'b0;
		end
	end

	// Result side: stall in random bursts, otherwise always ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			take_gap <= 0;
		end else if (take_gap != 0) begin
			result_ch.ready <= 1'b0;
			take_gap <= take_gap - 1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			result_ch.ready <= 1'b0;
			take_gap <= $urandom_range(0, 11);
		end else
			result_ch.ready <= 1'b1;
	end

	// Register write driver: no idling, the stimulus process waits for it anyway.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ch.valid <= 1'b0;
			cfg_ch.data <= '0;
		end else if (!cfg_ch.valid || cfg_ch.ready) begin
			if (reg_writes.size() != 0) begin
				cfg_ch.valid <= 1'b1;
				cfg_ch.data <= reg_writes.pop_front();
			end else
				cfg_ch.valid <= 1'b0;
		end
	end

	// Monitor: track register writes and accepted words in the shadow model, check
	// each returned read against the oldest expectation, and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				n_regw++;
				case (cfg_ch.data.index)
					fab_pkg::REG_FRAME_WIDTH: cfg_width = cfg_ch.data.value;
					fab_pkg::REG_FRAME_HEIGHT: cfg_height = cfg_ch.data.value;
					fab_pkg::REG_READ_FORMAT: cfg_fmt = cfg_ch.data.value[1:0];
					default: ;
				endcase
			end
			if (item_ch.valid && item_ch.ready)
				apply_pixel_op(item_ch.data);
			if (result_ch.valid && result_ch.ready) begin
				if (expected_reads.size() == 0) begin
					if (fault_count < 10)
						$display("unexpected read word %08h oor %0b",
							result_ch.data.pixel_word, result_ch.data.out_of_range);
					fault_count++;
				end else begin
					fab_pkg::result_t want;
					want = expected_reads.pop_front();
					if (result_ch.data.pixel_word !== want.pixel_word ||
							result_ch.data.out_of_range !== want.out_of_range) begin
						if (fault_count < 10)
							$display("read mismatch: expected %08h oor %0b, got %08h oor %0b",
								want.pixel_word, want.out_of_range,
								result_ch.data.pixel_word, result_ch.data.out_of_range);
						fault_count++;
					end
				end
			end
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles, %0d reads outstanding",
					quiet_cycles, expected_reads.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int ph_i, n;
		int unsigned we, he;
		logic [8:0] pw, ph;
		logic [1:0] pf;
		logic [8:0] fmt_val;
		fab_pkg::item_t it;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, reset geometry 256 x 256 in RGBA order. Nothing is taken
		// until the reset sweep ends.
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd0, 8'd0, '0));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_PLOT, 8'd255, 8'd255, 32'h123456FF));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd255, 8'd255, '0));
		// transparent plot must leave the pixel alone
		pending_items.push_back(pixel_op(fab_pkg::FUNC_PLOT, 8'd255, 8'd255, 32'hABCDEF00));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_PLOT, 8'd255, 8'd255, 32'hFF00FF80));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd255, 8'd255, '0));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_PLOT, 8'd0, 8'd0, 32'hFFFFFF01));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd0, 8'd0, '0));
		pending_items.push_back(pixel_op(FUNC_UNUSED, 8'd17, 8'd99, 32'hDEADBEEF));
		// one full-frame clear with the default background
		pending_items.push_back(pixel_op(fab_pkg::FUNC_CLEAR, 8'd0, 8'd0, 32'h141414FF));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_PLOT, 8'd128, 8'd77, 32'h000000FE));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd128, 8'd77, '0));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd0, 8'd0, '0));
		drain_block();

		// Tiny frame, BGRA: plots and reads on and just past the edges, and a clear
		// whose colour keeps its zero alpha.
		write_regs(9'd4, 9'd3, {7'd0, fab_pkg::FMT_BGRA});
		pending_items.push_back(pixel_op(fab_pkg::FUNC_PLOT, 8'd3, 8'd2, 32'h11223344));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_PLOT, 8'd4, 8'd0, 32'h556677FF));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd3, 8'd2, '0));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd4, 8'd2, '0));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd3, 8'd3, '0));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_CLEAR, 8'd0, 8'd0, 32'h0A0B0C00));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd0, 8'd0, '0));
		drain_block();

		// Empty frame: clear and plot do nothing, every read is out of range.
		write_regs(9'd0, 9'd0, {7'd0, fab_pkg::FMT_BGRX});
		pending_items.push_back(pixel_op(fab_pkg::FUNC_CLEAR, 8'd0, 8'd0, 32'hFFFFFFFF));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_PLOT, 8'd0, 8'd0, 32'hFFFFFFFF));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd0, 8'd0, '0));
		drain_block();

		// Oversized frame acts as the whole store; earlier pixels keep their places.
		write_regs(9'd300, 9'd511, {7'd0, fab_pkg::FMT_OPAQUE});
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd255, 8'd255, '0));
		pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd3, 8'd2, '0));
		drain_block();

		// Random phases, each under its own geometry and byte order. The last ones
		// run without any idling.
		for (ph_i = 0; ph_i < PHASES; ph_i++) begin
			case (ph_i)
				0: begin pw = 9'd1; ph = 9'd1; pf = fab_pkg::FMT_RGBA; end
				1: begin pw = 9'd256; ph = 9'd256; pf = fab_pkg::FMT_OPAQUE; end
				2: begin
					pw = 9'd0;
					ph = 9'($urandom_range(1, 256));
					pf = fab_pkg::FMT_BGRA;
				end
				3: begin pw = 9'd511; ph = 9'd7; pf = fab_pkg::FMT_BGRX; end
				4: begin pw = 9'd13; ph = 9'd511; pf = fab_pkg::FMT_OPAQUE; end
				5: begin
					pw = 9'($urandom_range(1, 256));
					ph = 9'd0;
					pf = fab_pkg::FMT_RGBA;
				end
				default: begin
					pw = 9'($urandom_range(1, 48));
					ph = 9'($urandom_range(1, 48));
					pf = 2'($urandom_range(0, 3));
				end
			endcase
			// upper bits of the format value are don't-care; toggle them now and then
			fmt_val = {($urandom_range(0, 1) != 0) ? 7'($urandom) : 7'd0, pf};
			if (ph_i == PHASES - 2)
				calm = 1'b1;
			if (ph_i == 6)
				reg_writes.push_back(fab_pkg::cfg_t'{index: REG_UNUSED,
					value: fab_pkg::size_t'($urandom)});
			write_regs(pw, ph, fmt_val);
			we = (pw > FB_W) ? FB_W : pw;
			he = (ph > FB_H) ? FB_H : ph;
			n = 0;
			while (n < WORDS_PER_PHASE) begin
				it = random_pixel_op(we, he, we * he <= CHEAP_CLEAR);
				pending_items.push_back(it);
				// plots and unused words the block simply drops do not count toward the phase
				if (it.func != FUNC_UNUSED && !(it.func == fab_pkg::FUNC_PLOT &&
						(it.color[7:0] == 8'h00 || it.pos_x >= we || it.pos_y >= he)))
					n++;
			end
			// close the phase with a read so the back end is known to be done
			pending_items.push_back(pixel_op(fab_pkg::FUNC_READ, 8'd0, 8'd0, '0));
			drain_block();
		end

		repeat (50) @(posedge clk);
		fault_count += expected_reads.size();
		$display("covered %0d plots, %0d clears, %0d reads (%0d out of range)",
			n_plot, n_clear, n_read, n_oor);
		$display("%0d register writes across %0d random phases plus the directed part",
			n_regw, PHASES);
		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
rtl/fab_pkg.sv
rtl/fab_stream_if.sv
rtl/fab_front.sv
rtl/fab_queue.sv
rtl/fab_back.sv
rtl/framebuffer_alpha_blend_store.sv
rtl/fab_checker.sv
dv/testbench.sv
